### sv/quadratic_probe_hash_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic probe hash table
// Shared property forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Types and constants shared by the hash table controller and datapath.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int unsigned VAL_W    = 31;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MAX_SLOTS = 1 << IDX_W;

  // Remainder unit: REM_BITS quotient bits per cycle.
  localparam int unsigned REM_BITS   = 4;
  localparam int unsigned REM_CYCLES = (VAL_W + REM_BITS - 1) / REM_BITS;
  localparam int unsigned REM_W      = REM_BITS * REM_CYCLES;
  localparam int unsigned REM_CNT_W  = (REM_CYCLES > 1) ? $clog2(REM_CYCLES) : 1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  typedef struct packed {
    logic                capture;
    logic                rem_start;
    logic                probe_init;
    logic                probe_rd;
    logic                probe_adv;
    logic                write;
    logic                load_out;
    logic [STATUS_W-1:0] status;
  } qpht_cmd_t;

  typedef struct packed {
    logic rem_done;
    logic table_full;
    logic slot_empty;
    logic slot_match;
    logic probe_last;
  } qpht_sts_t;

endpackage

### sv/qpht_rem.sv
// ----------------------------------------------------------------------------
// qpht_rem
// Iterative remainder unit: value modulo table size, four bits per cycle.
// ----------------------------------------------------------------------------
module qpht_rem
  import qpht_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [SIZE_W-1:0] modulus_i,
  output logic              done_o,
  output logic [SIZE_W-1:0] rem_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [REM_CNT_W-1:0] cnt_q;
  logic [REM_W-1:0]     sh_q, sh_d;
  logic [SIZE_W-1:0]    r_q, r_d;

  // Restoring remainder: the partial remainder stays below the modulus.
  always_comb begin
    logic [SIZE_W:0] rr;
    r_d  = r_q;
    sh_d = sh_q;
    for (int k = 0; k < REM_BITS; k++) begin
      rr = {r_d, sh_d[REM_W-1]};
      if (rr >= {1'b0, modulus_i}) begin
        rr = rr - {1'b0, modulus_i};
      end
      r_d  = rr[SIZE_W-1:0];
      sh_d = sh_d << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= REM_CNT_W'(REM_CYCLES - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= {{(REM_W - VAL_W){1'b0}}, value_i};
      r_q  <= '0;
    end else if (busy_q) begin
      sh_q <= sh_d;
      r_q  <= r_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

### sv/qpht_datapath.sv
// ----------------------------------------------------------------------------
// qpht_datapath
// Slot storage, probe sequence arithmetic, entry count and result register.
// ----------------------------------------------------------------------------
module qpht_datapath
  import qpht_pkg::*;
#(
  parameter int unsigned SLOTS = 256
)
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SIZE_W-1:0]   cfg_wdata_i,
  input  logic [VAL_W-1:0]    value_i,
  input  qpht_cmd_t           cmd_i,
  output qpht_sts_t           sts_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    slot_o
);

  localparam int unsigned SW = $clog2(SLOTS);

  logic [SIZE_W-1:0]   table_size_q;
  logic [SIZE_W-1:0]   size_min1;
  logic [SIZE_W-1:0]   n;
  logic [VAL_W-1:0]    value_q;
  logic [SIZE_W-1:0]   key_q, sq_q, d_q, step_q;
  logic [SIZE_W-1:0]   count_q;
  logic [SLOTS-1:0]    valid_q;
  logic [VAL_W-1:0]    mem [SLOTS];
  logic [VAL_W-1:0]    rd_q;
  logic                vld_rd_q;
  logic [STATUS_W-1:0] status_q;
  logic [IDX_W-1:0]    slot_q;
  logic                rem_done;
  logic [SIZE_W-1:0]   rem;
  logic [SW-1:0]       idx;

  // Sum of two residues below the modulus, reduced once.
  function automatic logic [SIZE_W-1:0] add_mod(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b,
                                                input logic [SIZE_W-1:0] m);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[SIZE_W-1:0];
  endfunction

  // A zero size acts as one; sizes beyond the storage saturate.
  assign size_min1 = (table_size_q == '0) ? SIZE_W'(1) : table_size_q;
  assign n = (size_min1 > SIZE_W'(SLOTS)) ? SIZE_W'(SLOTS) : size_min1;
  assign idx = key_q[SW-1:0];

  qpht_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.rem_start),
    .value_i   (value_i),
    .modulus_i (n),
    .done_o    (rem_done),
    .rem_o     (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SIZE_W'(MAX_SLOTS);
      count_q      <= '0;
      valid_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        table_size_q <= cfg_wdata_i;
      end
      if (cmd_i.write) begin
        valid_q[idx] <= 1'b1;
        count_q      <= count_q + 1'b1;
      end
    end
  end

  // The step of probe i is i*i mod n, kept as a running residue together with
  // the residue of 2i+1, so each advance is three modular additions.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      value_q <= value_i;
    end
    if (cmd_i.probe_init) begin
      key_q  <= rem;
      step_q <= SIZE_W'(1);
      sq_q   <= (n == SIZE_W'(1)) ? '0 : SIZE_W'(1);
      d_q    <= (n > SIZE_W'(3)) ? SIZE_W'(3) : ((n == SIZE_W'(2)) ? SIZE_W'(1) : '0);
    end else if (cmd_i.probe_adv) begin
      key_q  <= add_mod(key_q, sq_q, n);
      sq_q   <= add_mod(sq_q, d_q, n);
      d_q    <= (n == SIZE_W'(1)) ? '0 : add_mod(d_q, SIZE_W'(2), n);
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.probe_rd) begin
      vld_rd_q <= valid_q[idx];
    end
    if (cmd_i.load_out) begin
      status_q <= cmd_i.status;
      slot_q   <= (cmd_i.status == ST_INSERTED || cmd_i.status == ST_FOUND)
                  ? IDX_W'(key_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[idx] <= value_q;
    end
    if (cmd_i.probe_rd) begin
      rd_q <= mem[idx];
    end
  end

  assign sts_o.rem_done   = rem_done;
  assign sts_o.table_full = (count_q >= n);
  assign sts_o.slot_empty = !vld_rd_q;
  assign sts_o.slot_match = (rd_q == value_q);
  assign sts_o.probe_last = (step_q == n);

  assign status_o = status_q;
  assign slot_o   = slot_q;

endmodule

### sv/qpht_ctrl.sv
// ----------------------------------------------------------------------------
// qpht_ctrl
// Request sequencer: remainder, probe loop, and result hand-off.
// ----------------------------------------------------------------------------
`include "quadratic_probe_hash_table_assert.svh"

module qpht_ctrl
  import qpht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  logic      s_axis_tuser,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  input  qpht_sts_t sts_i,
  output qpht_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_REPLY
  } state_e;

  state_e              state_q;
  logic                ready_q;
  logic                out_valid_q;
  logic                search_q;
  logic [STATUS_W-1:0] status_q;
  logic                accept;
  logic                go_full;
  logic                out_free;

  assign accept   = s_axis_tvalid && ready_q;
  assign go_full  = (s_axis_tuser == CMD_INSERT) && sts_i.table_full;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    cmd_o            = '0;
    cmd_o.status     = status_q;
    cmd_o.capture    = accept;
    cmd_o.rem_start  = accept && !go_full;
    cmd_o.probe_init = (state_q == S_MOD) && sts_i.rem_done;
    cmd_o.probe_rd   = (state_q == S_READ);
    cmd_o.load_out   = (state_q == S_REPLY) && out_free;
    if (state_q == S_CHECK) begin
      cmd_o.write     = !search_q && sts_i.slot_empty;
      cmd_o.probe_adv = !sts_i.slot_empty && !(search_q && sts_i.slot_match)
                        && !sts_i.probe_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b1;
      out_valid_q <= 1'b0;
      search_q    <= 1'b0;
      status_q    <= ST_INSERTED;
    end else begin
      // A new result replaces one that is being taken in the same cycle.
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ready_q  <= 1'b0;
            search_q <= (s_axis_tuser == CMD_SEARCH);
            if (go_full) begin
              status_q <= ST_FULL;
              state_q  <= S_REPLY;
            end else begin
              state_q <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (sts_i.rem_done) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (sts_i.slot_empty) begin
            status_q <= search_q ? ST_MISSING : ST_INSERTED;
            state_q  <= S_REPLY;
          end else if (search_q && sts_i.slot_match) begin
            status_q <= ST_FOUND;
            state_q  <= S_REPLY;
          end else if (sts_i.probe_last) begin
            status_q <= search_q ? ST_MISSING : ST_FULL;
            state_q  <= S_REPLY;
          end else begin
            state_q <= S_READ;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign s_axis_tready = ready_q;
  assign m_axis_tvalid = out_valid_q;

  `QPHT_ASSERT_NOW(a_write_on_empty, clk_i, rst_ni, cmd_o.write, state_q == S_CHECK && sts_i.slot_empty && !search_q, "table write outside an insert into an empty slot")
  `QPHT_ASSERT_NOW(a_load_when_free, clk_i, rst_ni, cmd_o.load_out, !out_valid_q || m_axis_tready, "result loaded over an unread result")
  `QPHT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, cmd_o.capture, !ready_q && (state_q == S_MOD || state_q == S_REPLY), "request accepted without leaving idle")

endmodule

### sv/quadratic_probe_hash_table.sv
// An insert into a full table goes straight to the result; any other request first runs
// the remainder unit to the home slot, then reads and checks each probed slot, P of them
// (1 to size), and loads the result. One request is in flight: the next is taken the cycle
// after the result is loaded, while that result may still wait.
// Reset empties every slot at once through per-slot valid flags, zeroes the entry
// count and sets the table size to 256; no clearing pass is needed.
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table with quadratic probing, insert and search.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table
  import qpht_pkg::*;
#(
  parameter int unsigned DEPTH = 256
)
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,   // table size
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // [30:0] data_value
  input  logic [0:0]        s_axis_tuser,  // [0] cmd
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // [7:0] slot_index
  output logic [1:0]        m_axis_tuser   // [1:0] status
);

  // Only the first 256 slots are reachable with an 8-bit slot index.
  localparam int unsigned SLOTS = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;

  qpht_cmd_t cmd;
  qpht_sts_t sts;

  qpht_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser[0]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  qpht_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (s_axis_tdata[VAL_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .status_o    (m_axis_tuser),
    .slot_o      (m_axis_tdata)
  );

endmodule
